>>> hdl/psmr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the seed-mix line function for the
// position-seeded generator. No dependencies.
package psmr_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} in_t;

	typedef struct packed {
		logic [30:0]        seed_out;
		logic signed [31:0] range_value;
	} out_t;

	typedef struct packed {
		logic [31:0] p;
		logic [31:0] q;
		logic [31:0] r;
	} mix_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd2;

	localparam logic [31:0]        BASE_SEED_RST  = 32'd0;
	localparam logic signed [31:0] RANGE_LOW_RST  = 32'sd0;
	localparam logic signed [31:0] RANGE_HIGH_RST = 32'sd1;

	localparam logic [31:0] MIX_XOR = 32'h93262e6f;
	// The position multiplier 134217727 is 2^27 - 1.
	localparam int POS_SHIFT = 27;
	localparam logic signed [31:0] Y_LIMIT = 32'sd102400;
	// 3483.328 in Q12.40: integer part and 40-bit fraction.
	localparam logic [11:0] C_INT  = 12'd3483;
	localparam logic [38:0] C_FRAC = 39'd360639813911;

	localparam logic [14:0] PM_MUL    = 15'd16807;
	localparam logic [30:0] PM_MOD    = 31'h7fffffff;
	localparam logic [30:0] SCALE_NUM = 31'd2147483639;
	localparam logic [31:0] SCALE_DEN = 32'hffffffff;
	// The range fraction 8589934596 / 2^64 is (2^33 + 2^2) / 2^64.
	localparam int K_SHIFT_HI = 33;
	localparam int K_SHIFT_LO = 2;

	localparam int MIX_LINES = 9;
	localparam logic [4:0] MIX_SHIFT [MIX_LINES] = '{
		5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
	};
	// Mix lines rotate through the three words p, q, r in this order.
	localparam logic [1:0] MIX_ROLE_P = 2'd0;
	localparam logic [1:0] MIX_ROLE_Q = 2'd1;
	localparam logic [1:0] MIX_ROLE_R = 2'd2;

	// Cycles from an accepted start to the done strobe.
	localparam int LATENCY = 30;

	function automatic mix_t mix_line(input logic [1:0] role, input logic [4:0] sh,
			input mix_t st);
		mix_t o;
		o = st;
		unique case (role)
			MIX_ROLE_P: o.p = (st.p - st.q - st.r) ^ (st.r >> sh);
			MIX_ROLE_Q: o.q = (st.q - st.p - st.r) ^ (st.p << sh);
			MIX_ROLE_R: o.r = (st.r - st.p - st.q) ^ (st.q >> sh);
			default:    o = st;
		endcase
		return o;
	endfunction

endpackage

>>> hdl/psmr_mix.sv
`timescale 1ns / 1ps
// Nine-stage pipeline of the Jenkins-style seed mix, one mix line per stage.
// Depends on psmr_pkg.
module psmr_mix import psmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] ws,
	output logic        out_vld,
	output logic [31:0] g
);

	logic [MIX_LINES-1:0] vld_s;
	mix_t                 st_s   [MIX_LINES];
	mix_t                 stg_in [MIX_LINES];

	for (genvar i = 0; i < MIX_LINES; i++) begin : g_line
		localparam logic [1:0] ROLE = 2'(i % 3);

		if (i == 0) begin : g_first
			// The base seed starts out as the third word of the mix.
			assign stg_in[i] = '{p: a, q: b, r: ws};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[i] <= 1'b0;
				else         vld_s[i] <= in_vld;
			end
		end else begin : g_next
			assign stg_in[i] = st_s[i-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[i] <= 1'b0;
				else         vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			st_s[i] <= mix_line(ROLE, MIX_SHIFT[i], stg_in[i]);
		end
	end

	assign out_vld = vld_s[MIX_LINES-1];
	assign g       = st_s[MIX_LINES-1].r;

endmodule

>>> hdl/psmr_mstep.sv
`timescale 1ns / 1ps
// One Park-Miller step (s * 16807 mod 2^31-1) in two stages, with a bypass
// when the step is disabled. Depends on psmr_pkg.
module psmr_mstep import psmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic        en,
	input  logic [30:0] s_in,
	output logic        out_vld,
	output logic [30:0] s_out
);

	logic        vld_s1, vld_s2;
	logic        en_s1;
	logic [30:0] s_s1, s_s2;
	logic [45:0] prod_s1;
	logic [31:0] fold;
	logic [31:0] red;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		en_s1   <= en;
		s_s1    <= s_in;
		prod_s1 <= {15'b0, s_in} * {31'b0, PM_MUL};
	end

	// 2^31 is 1 modulo 2^31-1, so the high part folds onto the low part.
	assign fold = {17'b0, prod_s1[45:31]} + {1'b0, prod_s1[30:0]};
	assign red  = (fold >= {1'b0, PM_MOD}) ? fold - {1'b0, PM_MOD} : fold;

	always_ff @(posedge clk) begin
		s_s2 <= en_s1 ? red[30:0] : s_s1;
	end

	assign out_vld = vld_s2;
	assign s_out   = s_s2;

endmodule

>>> hdl/position_seeded_minstd_random_top.sv
`timescale 1ns / 1ps
// Top level of the position-seeded MINSTD generator: configuration registers,
// word forming, scaling and range mapping. Depends on psmr_pkg, psmr_mix, psmr_mstep.
//
// Usage:
// - Input: a transaction is taken at a rising edge where start is high and busy
//   is low. pos carries the signed position (pos_x, pos_y).
// - Output: done is high for exactly one cycle with result (seed_out and
//   range_value). The receiver cannot hold results off.
// - A new position can be taken every cycle while busy is low, so throughput
//   is one transaction per cycle; the 30-stage pipeline sets the latency (six
//   word forming stages, nine mix stages, two scaling stages, five Park-Miller
//   steps of two stages each, three range stages).
// - Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 is
//   base_seed, 1 range_low, 2 range_high; index 3 is ignored. Write only
//   while no transaction is in flight.
// - Reset: arst_n clears the pipeline valid bits and restores the registers
//   to base_seed 0, range_low 0, range_high 1. busy is high during reset and
//   for the first edge after it, low after that.
module position_seeded_minstd_random_top import psmr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  in_t                  pos,
	output logic                 busy,
	output logic                 done,
	output out_t                 result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic               busy_q;
	logic [31:0]        base_seed_q;
	logic signed [31:0] range_low_q, range_high_q;
	logic [31:0]        nmag_q;
	logic               nneg_q;
	logic [31:0]        n_c;
	logic [31:0]        k;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b1;
		else         busy_q <= 1'b0;
	end

	assign busy      = busy_q;
	assign cfg_ready = ~busy_q;
	assign accept    = start & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seed_q  <= BASE_SEED_RST;
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BASE_SEED:  base_seed_q  <= cfg_data;
				CFG_RANGE_LOW:  range_low_q  <= cfg_data;
				CFG_RANGE_HIGH: range_high_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Range width, wrapping at 32 bits, kept as magnitude and sign.
	assign n_c = range_high_q - range_low_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmag_q <= 32'd2;
			nneg_q <= 1'b0;
		end else begin
			nmag_q <= n_c[31] ? 32'd0 - n_c : n_c;
			nneg_q <= n_c[31];
		end
	end

	assign k = base_seed_q ^ MIX_XOR;

	// Stage 1: offset coordinates.
	logic        vld_s1;
	logic [31:0] xw_s1, yw_s1;

	always_ff @(posedge clk) begin
		xw_s1 <= 32'(pos.pos_x) + 32'(k[11:0]);
		yw_s1 <= 32'(pos.pos_y) + 32'(k[23:12]);
	end

	// Stage 2: linear words, branch choice and the square of y.
	logic               vld_s2;
	logic [31:0]        e_raw, e_c, w2a_c;
	logic signed [31:0] ys_c;
	logic signed [17:0] y18_c;
	logic signed [35:0] ysq_c;
	logic               sel_c;
	logic [31:0]        e_s2, w2a_s2;
	logic               sel_s2;
	logic signed [17:0] y18_s2;
	logic [33:0]        y2_s2;

	assign e_raw = (xw_s1 << POS_SHIFT) - xw_s1;
	assign e_c   = (e_raw == 32'd0) ? 32'd2 : e_raw;
	assign w2a_c = (yw_s1 << POS_SHIFT) - yw_s1;
	assign ys_c  = $signed(yw_s1);
	assign sel_c = (ys_c >= Y_LIMIT) || (ys_c <= -Y_LIMIT)
		|| (xw_s1 == 32'd0) || (xw_s1 == 32'd1) || (xw_s1 == 32'hffffffff);
	// On the quadratic branch |y| is below 2^17, so 18 signed bits hold it.
	assign y18_c = $signed(yw_s1[17:0]);
	assign ysq_c = y18_c * y18_c;

	always_ff @(posedge clk) begin
		e_s2   <= e_c;
		w2a_s2 <= w2a_c;
		sel_s2 <= sel_c;
		y18_s2 <= y18_c;
		y2_s2  <= ysq_c[33:0];
	end

	// Stage 3: partial products of y^2 * C and y * e.
	logic               vld_s3;
	logic [53:0]        lo_c, lo_s3;
	logic [52:0]        hm_c, hm_s3;
	logic [45:0]        yc_c, yc_s3;
	logic signed [50:0] ye_c, ye_s3;
	logic [31:0]        e_s3, w2a_s3;
	logic               sel_s3;

	assign lo_c = {20'b0, y2_s2} * {34'b0, C_FRAC[19:0]};
	assign hm_c = {19'b0, y2_s2} * {34'b0, C_FRAC[38:20]};
	assign yc_c = {12'b0, y2_s2} * {34'b0, C_INT};
	assign ye_c = 51'(y18_s2) * $signed({19'b0, e_s2});

	always_ff @(posedge clk) begin
		lo_s3  <= lo_c;
		hm_s3  <= hm_c;
		yc_s3  <= yc_c;
		ye_s3  <= ye_c;
		e_s3   <= e_s2;
		w2a_s3 <= w2a_s2;
		sel_s3 <= sel_s2;
	end

	// Stage 4: combine the fraction products, sum the integer terms.
	logic               vld_s4;
	logic [53:0]        mid_s4;
	logic               lofz_s4;
	logic signed [51:0] p_s4;
	logic [31:0]        e_s4, w2a_s4;
	logic               sel_s4;

	always_ff @(posedge clk) begin
		mid_s4  <= {1'b0, hm_s3} + {20'b0, lo_s3[53:20]};
		lofz_s4 <= |lo_s3[19:0];
		p_s4    <= $signed({6'b0, yc_s3}) + 52'(ye_s3);
		e_s4    <= e_s3;
		w2a_s4  <= w2a_s3;
		sel_s4  <= sel_s3;
	end

	// Stage 5: full quadratic value and its dropped fraction.
	logic               vld_s5;
	logic signed [51:0] v_s5;
	logic               frac_s5;
	logic [31:0]        e_s5, w2a_s5;
	logic               sel_s5;

	always_ff @(posedge clk) begin
		v_s5    <= p_s4 + $signed({18'b0, mid_s4[53:20]});
		frac_s5 <= lofz_s4 | (|mid_s4[19:0]);
		e_s5    <= e_s4;
		w2a_s5  <= w2a_s4;
		sel_s5  <= sel_s4;
	end

	// Stage 6: second word. A negative value with a fraction truncates toward zero.
	logic        vld_s6;
	logic [31:0] w2_s6, e_s6;

	always_ff @(posedge clk) begin
		w2_s6 <= sel_s5 ? w2a_s5 : v_s5[31:0] + {31'b0, v_s5[51] & frac_s5};
		e_s6  <= e_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stages 7 to 15: seed mix.
	logic        mix_vld;
	logic [31:0] mix_g;

	psmr_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s6),
		.a       (e_s6),
		.b       (w2_s6),
		.ws      (base_seed_q),
		.out_vld (mix_vld),
		.g       (mix_g)
	);

	// Stages 16 and 17: floor(g * N / (2^32 - 1)) + 1. With P = g * N split
	// as q * 2^32 + r, the quotient is q plus one when q + r reaches 2^32 - 1.
	logic        vld_s16, vld_s17;
	logic [62:0] prod_s16;
	logic [32:0] qr_sum;
	logic        corr;
	logic [30:0] s0_s17;

	assign qr_sum = {2'b0, prod_s16[62:32]} + {1'b0, prod_s16[31:0]};
	assign corr   = qr_sum >= {1'b0, SCALE_DEN};

	always_ff @(posedge clk) begin
		prod_s16 <= {31'b0, mix_g} * {32'b0, SCALE_NUM};
		s0_s17   <= prod_s16[62:32] + 31'(corr) + 31'd1;
	end

	// Stages 18 to 27: one fixed step, three warm-up steps that the low
	// base seed bits enable, and the step that feeds the range.
	logic        st1_vld, st2_vld, st3_vld, st4_vld, st5_vld;
	logic [30:0] st1_s, st2_s, st3_s, st4_s, st5_s;

	psmr_mstep u_step1 (
		.clk (clk), .arst_n (arst_n), .in_vld (vld_s17), .en (1'b1),
		.s_in (s0_s17), .out_vld (st1_vld), .s_out (st1_s)
	);
	psmr_mstep u_step2 (
		.clk (clk), .arst_n (arst_n), .in_vld (st1_vld), .en (|base_seed_q[1:0]),
		.s_in (st1_s), .out_vld (st2_vld), .s_out (st2_s)
	);
	psmr_mstep u_step3 (
		.clk (clk), .arst_n (arst_n), .in_vld (st2_vld), .en (base_seed_q[1]),
		.s_in (st2_s), .out_vld (st3_vld), .s_out (st3_s)
	);
	psmr_mstep u_step4 (
		.clk (clk), .arst_n (arst_n), .in_vld (st3_vld), .en (&base_seed_q[1:0]),
		.s_in (st3_s), .out_vld (st4_vld), .s_out (st4_s)
	);
	psmr_mstep u_step5 (
		.clk (clk), .arst_n (arst_n), .in_vld (st4_vld), .en (1'b1),
		.s_in (st4_s), .out_vld (st5_vld), .s_out (st5_s)
	);

	// The warmed-up seed travels alongside the last step and the range stages.
	logic [30:0] seed_s26, seed_s27, seed_s28, seed_s29;

	always_ff @(posedge clk) begin
		seed_s26 <= st4_s;
		seed_s27 <= seed_s26;
		seed_s28 <= seed_s27;
		seed_s29 <= seed_s28;
	end

	// Stages 28 to 30: range mapping, |n| * s * K truncated, sign reapplied.
	logic        vld_s28, vld_s29, vld_s30;
	logic [62:0] a_s28;
	logic [95:0] ak_c;
	logic [31:0] res_s29;
	out_t        out_s30;

	assign ak_c = {a_s28, {K_SHIFT_HI{1'b0}}}
		+ {{(96 - 63 - K_SHIFT_LO){1'b0}}, a_s28, {K_SHIFT_LO{1'b0}}};

	always_ff @(posedge clk) begin
		a_s28   <= {31'b0, nmag_q} * {32'b0, st5_s};
		res_s29 <= ak_c[95:64];
		out_s30.seed_out    <= seed_s29;
		out_s30.range_value <= nneg_q ? range_low_q - $signed(res_s29)
			: range_low_q + $signed(res_s29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
			vld_s28 <= 1'b0;
			vld_s29 <= 1'b0;
			vld_s30 <= 1'b0;
		end else begin
			vld_s16 <= mix_vld;
			vld_s17 <= vld_s16;
			vld_s28 <= st5_vld;
			vld_s29 <= vld_s28;
			vld_s30 <= vld_s29;
		end
	end

	assign done   = vld_s30;
	assign result = out_s30;

endmodule

>>> hdl/psmr_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the generator top level, attached by bind.
// Depends on psmr_pkg and position_seeded_minstd_random_top.
module psmr_checker import psmr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t result
);

	// Every taken transaction gives exactly one strobe after the fixed latency.
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("done missing after an accepted start");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without a matching start");

	// A Park-Miller state never reaches zero or the modulus.
	a_seed_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.seed_out != 31'd0) && (result.seed_out != PM_MOD))
		else $error("seed_out outside the generator range");

	a_busy_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy held after reset");

endmodule

bind position_seeded_minstd_random_top psmr_checker u_psmr_checker (.*);
